@@ sv/packed_element_store_unit_assert.svh @@
// Assertion macros shared by the packed element store RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef PACKED_ELEMENT_STORE_UNIT_ASSERT_SVH
`define PACKED_ELEMENT_STORE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PES_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/pes_pkg.sv @@
// ----------------------------------------------------------------------------
// pes_pkg
// Types and constants shared by the packed element store and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package pes_pkg;

	localparam int unsigned PES_STORE_WORDS = 256;
	localparam int unsigned PES_WORD_BITS   = 64;

	// Field widths of the request and response items.
	localparam int unsigned PES_INDEX_W = 14;
	localparam int unsigned PES_VALUE_W = 64;

	// Configuration register widths and the APB address width.
	localparam int unsigned PES_EWIDTH_W = 7;
	localparam int unsigned PES_ECOUNT_W = 15;
	localparam int unsigned PES_ADDR_W   = 3;
	localparam int unsigned PES_DATA_W   = 32;

	// Register indexes as decoded from paddr[2].
	localparam logic [0:0] REG_ELEMENT_WIDTH = 1'b0;
	localparam logic [0:0] REG_ELEMENT_COUNT = 1'b1;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_READ,
		ST_MOD
	} pes_state_t;

endpackage

`default_nettype wire

@@ sv/pes_req_if.sv @@
// ----------------------------------------------------------------------------
// pes_req_if
// Request channel: one read or write of a packed element per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pes_req_if;
	import pes_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   opcode;
	logic [PES_INDEX_W-1:0] index;
	logic [PES_VALUE_W-1:0] write_value;

	modport source (output valid, output opcode, output index, output write_value,
		input ready);
	modport sink (input valid, input opcode, input index, input write_value,
		output ready);
endinterface

`default_nettype wire

@@ sv/pes_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pes_rsp_if
// Response channel: one result per request transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pes_rsp_if;
	import pes_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [PES_VALUE_W-1:0] read_value;
	logic                   status;
	logic                   ambiguous;

	modport source (output valid, output read_value, output status, output ambiguous,
		input ready);
	modport sink (input valid, input read_value, input status, input ambiguous,
		output ready);
endinterface

`default_nettype wire

@@ sv/packed_element_store_unit.sv @@
// ----------------------------------------------------------------------------
// packed_element_store_unit
// Bit store of 64-bit words holding elements packed back to back.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req (valid/ready). A read returns the element at index
// and flags it ambiguous when its population count is not exactly one; a
// write replaces only that element's bits. An index at or past element_count,
// or an element reaching past the store, returns status 1 and changes nothing.
// element_width and element_count are set over the APB port at byte
// addresses 0 and 4; the user must write them only while no request is in
// flight, which the block itself does not enforce. Each request goes through
// accept, address multiply and range check, memory read, then modify and
// write back. The store is split into an even and an odd word bank so both
// words of a straddling element are read together and written together; the
// read-modify-write of one request finishes before the next is accepted. The
// response is loaded into an output register at write-back; a stalled
// receiver holds the block in its write-back state until the register frees
// up. After reset the banks, of ceil(STORE_WORDS / 2) rows each, are cleared
// one row per cycle; req.ready stays low until it is done.
// ----------------------------------------------------------------------------
`default_nettype none
`include "packed_element_store_unit_assert.svh"

module packed_element_store_unit #(
	parameter int unsigned STORE_WORDS = pes_pkg::PES_STORE_WORDS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [pes_pkg::PES_ADDR_W-1:0]  paddr,
	input  wire logic [pes_pkg::PES_DATA_W-1:0]  pwdata,
	output logic      [pes_pkg::PES_DATA_W-1:0]  prdata,
	output logic                                 pready,
	pes_req_if.sink                              req,
	pes_rsp_if.source                            rsp
);
	import pes_pkg::*;

	localparam int unsigned BANK_D     = (STORE_WORDS + 1) / 2;
	localparam int unsigned BA_W       = (BANK_D > 1) ? $clog2(BANK_D) : 1;
	localparam int unsigned TOTAL_BITS = STORE_WORDS * PES_WORD_BITS;
	localparam int unsigned END_W      = 23;
	localparam int unsigned POS_W      = 20;
	localparam int unsigned WORD_W     = POS_W - 6;
	localparam int unsigned W          = PES_WORD_BITS;

	// Configuration registers.
	logic [PES_EWIDTH_W-1:0] ewidth_q;
	logic [PES_ECOUNT_W-1:0] ecount_q;
	logic                    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ewidth_q <= PES_EWIDTH_W'(64);
			ecount_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2:2])
				REG_ELEMENT_WIDTH: ewidth_q <= pwdata[PES_EWIDTH_W-1:0];
				REG_ELEMENT_COUNT: ecount_q <= pwdata[PES_ECOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2:2])
			REG_ELEMENT_WIDTH: prdata = PES_DATA_W'(ewidth_q);
			REG_ELEMENT_COUNT: prdata = PES_DATA_W'(ecount_q);
			default:           prdata = '0;
		endcase
	end

	// Control.
	pes_state_t state_q, state_d;
	logic [BA_W-1:0] clr_q;
	logic            accept;
	logic            slot_free;
	logic            clr_last;

	logic                   out_valid_q;
	logic [PES_VALUE_W-1:0] out_value_q;
	logic                   out_status_q;
	logic                   out_amb_q;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign clr_last  = (clr_q == BA_W'(BANK_D - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = ST_CALC;
			ST_CALC:  state_d = ST_READ;
			ST_READ:  state_d = ST_MOD;
			ST_MOD:   if (slot_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + BA_W'(1);
		end
	end

	// Request capture. Width values above 64 saturate.
	logic                   op_q;
	logic [PES_INDEX_W-1:0] idx_q;
	logic [PES_VALUE_W-1:0] wv_q;
	logic [6:0]             w_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.opcode;
			idx_q <= req.index;
			wv_q  <= req.write_value;
			w_q   <= (ewidth_q > 7'd64) ? 7'd64 : ewidth_q;
		end
	end

	// Bit position, range check and word split.
	logic [POS_W-1:0]  pos;
	logic [END_W-1:0]  end_bit;
	logic              range_err;
	logic [WORD_W-1:0] word_q;
	logic [5:0]        off_q;
	logic              split_q;
	logic              err_q;
	logic              zero_q;

	assign pos       = POS_W'(idx_q) * POS_W'(w_q);
	assign end_bit   = END_W'(pos) + END_W'(w_q);
	assign range_err = ({1'b0, idx_q} >= ecount_q) || (end_bit > END_W'(TOTAL_BITS));

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			word_q  <= pos[POS_W-1:6];
			off_q   <= pos[5:0];
			split_q <= ({2'b00, pos[5:0]} + {1'b0, w_q}) > 8'd64;
			err_q   <= range_err;
			zero_q  <= (w_q == 7'd0);
		end
	end

	// Word banks: even words in one, odd words in the other, so the two
	// words of a straddling element always sit in different banks.
	logic [W-1:0] even_mem [BANK_D];
	logic [W-1:0] odd_mem  [BANK_D];
	logic [W-1:0] even_rd_q, odd_rd_q;
	logic [BA_W-1:0] even_addr, odd_addr;
	logic [BA_W-1:0] even_waddr, odd_waddr;
	logic [W-1:0]    even_wdata, odd_wdata;
	logic            even_we, odd_we;
	logic            rd_en;

	assign odd_addr  = BA_W'(word_q >> 1);
	assign even_addr = BA_W'((15'(word_q) + 15'd1) >> 1);
	assign rd_en     = (state_q == ST_READ) && !err_q && !zero_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			even_rd_q <= even_mem[even_addr];
			odd_rd_q  <= odd_mem[odd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (even_we) begin
			even_mem[even_waddr] <= even_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (odd_we) begin
			odd_mem[odd_waddr] <= odd_wdata;
		end
	end

	// Extract and merge.
	logic [W-1:0]   lo_word, hi_word, mask, rd_val;
	logic [2*W-1:0] pair, wmask, wbits, merged;
	logic           rd_amb;
	logic           do_write;

	assign lo_word = word_q[0] ? odd_rd_q : even_rd_q;
	assign hi_word = word_q[0] ? even_rd_q : odd_rd_q;
	assign pair    = {hi_word, lo_word};
	assign mask    = ~({W{1'b1}} << w_q);
	assign rd_val  = W'(pair >> off_q) & mask;
	assign rd_amb  = ($countones(rd_val) != 1);
	assign wmask   = {{W{1'b0}}, mask} << off_q;
	assign wbits   = {{W{1'b0}}, wv_q & mask} << off_q;
	assign merged  = (pair & ~wmask) | wbits;

	// The write-back happens in the same cycle that the response is loaded,
	// and no later request can read before it lands.
	assign do_write = (state_q == ST_MOD) && slot_free && (op_q == OP_WRITE)
		&& !err_q && !zero_q;

	always_comb begin
		if (state_q == ST_CLEAR) begin
			even_we    = 1'b1;
			odd_we     = 1'b1;
			even_waddr = clr_q;
			odd_waddr  = clr_q;
			even_wdata = '0;
			odd_wdata  = '0;
		end else begin
			even_we    = do_write && (!word_q[0] || split_q);
			odd_we     = do_write && (word_q[0] || split_q);
			even_waddr = even_addr;
			odd_waddr  = odd_addr;
			even_wdata = word_q[0] ? merged[2*W-1:W] : merged[W-1:0];
			odd_wdata  = word_q[0] ? merged[W-1:0] : merged[2*W-1:W];
		end
	end

	// Response register.
	logic load_out;
	logic rd_ok;

	assign load_out = (state_q == ST_MOD) && slot_free;
	assign rd_ok    = (op_q == OP_READ) && !err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q  <= rd_ok ? rd_val : '0;
			out_status_q <= err_q ? STATUS_RANGE : STATUS_OK;
			out_amb_q    <= rd_ok && rd_amb;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = out_value_q;
	assign rsp.status     = out_status_q;
	assign rsp.ambiguous  = out_amb_q;

	`PES_ASSERT_SAME(a_write_when_allowed, even_we || odd_we,
		state_q == ST_CLEAR || state_q == ST_MOD, "bank write outside clear or write-back")
	`PES_ASSERT_NEXT(a_accept_starts_calc, accept, state_q == ST_CALC,
		"request transfer did not start address calculation")
	`PES_ASSERT_NEXT(a_load_shows_result, load_out, rsp.valid,
		"loaded result not presented")
	`PES_ASSERT_SAME(a_error_is_clean, rsp.valid && rsp.status == STATUS_RANGE,
		rsp.read_value == '0 && !rsp.ambiguous, "range error carries data")

endmodule

`default_nettype wire
